/* rtl/sisu_pkg.sv */
// Shared types and constants for the 16-bit ISA step unit.
// No dependencies.
`timescale 1ns / 1ps
package sisu_pkg;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_SET  = 2'd1;
  localparam logic [1:0] REQ_STEP = 2'd2;

  localparam logic [3:0] IDX_PC = 4'd8;
  localparam logic [3:0] IDX_CC = 4'd9;

  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [7:0] TRAP_HALT_VEC = 8'h25;

  localparam logic [2:0] CC_P = 3'b001;
  localparam logic [2:0] CC_Z = 3'b010;
  localparam logic [2:0] CC_N = 3'b100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FETCH,
    ST_DECODE,
    ST_IND,
    ST_MEM,
    ST_EXEC,
    ST_DONE
  } state_e;

  // memory port selection
  typedef enum logic [2:0] {
    AS_REQ,
    AS_CLR,
    AS_PC,
    AS_EA,
    AS_IND
  } addr_sel_e;

  typedef struct packed {
    logic      clr_step;
    logic      clr_wr;
    logic      mem_re;
    addr_sel_e addr_sel;
    logic      latch_req;
    logic      do_req;
    logic      latch_ir;
    logic      latch_ind;
    logic      do_exec;
    logic      done;
  } ctrl_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] req_type;
    logic [3:0] opcode;
  } status_t;

  function automatic logic [15:0] sext9(input logic [15:0] w);
    return {{7{w[8]}}, w[8:0]};
  endfunction

  function automatic logic [15:0] sext6(input logic [15:0] w);
    return {{10{w[5]}}, w[5:0]};
  endfunction

  function automatic logic [15:0] sext5(input logic [15:0] w);
    return {{11{w[4]}}, w[4:0]};
  endfunction

  function automatic logic [15:0] sext11(input logic [15:0] w);
    return {{5{w[10]}}, w[10:0]};
  endfunction

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v == 16'd0) begin
      return CC_Z;
    end else if (v[15]) begin
      return CC_N;
    end
    return CC_P;
  endfunction

endpackage

/* rtl/sisu_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sisu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sisu_ctrl.sv */
// Controller state machine of the step unit.
// Depends on sisu_pkg.
`timescale 1ns / 1ps
module sisu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sisu_pkg::status_t status_i,
  output sisu_pkg::ctrl_t   ctrl_o,
  output logic             busy_o
);
  import sisu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    ctrl_o.addr_sel = AS_REQ;
    busy_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        ctrl_o.addr_sel = AS_CLR;
        ctrl_o.clr_wr = 1'b1;
        ctrl_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.latch_req = 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (status_i.req_type == REQ_STEP) begin
          ctrl_o.addr_sel = AS_PC;
          ctrl_o.mem_re = 1'b1;
          state_d = ST_DECODE;
        end else begin
          ctrl_o.do_req = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DECODE: begin
        ctrl_o.latch_ir = 1'b1;
        state_d = ST_MEM;
      end
      ST_MEM: begin
        ctrl_o.addr_sel = AS_EA;
        ctrl_o.mem_re = 1'b1;
        if (status_i.opcode == OP_LDI || status_i.opcode == OP_STI) begin
          state_d = ST_IND;
        end else begin
          state_d = ST_EXEC;
        end
      end
      ST_IND: begin
        ctrl_o.latch_ind = 1'b1;
        ctrl_o.addr_sel = AS_IND;
        ctrl_o.mem_re = 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        ctrl_o.do_exec = 1'b1;
        ctrl_o.addr_sel = (status_i.opcode == OP_STI) ? AS_IND : AS_EA;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        ctrl_o.done = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sisu_dp.sv */
// Datapath of the step unit: registers, PC, condition code, memory port.
// Depends on sisu_pkg and sisu_ram.
`timescale 1ns / 1ps
module sisu_dp #(
  parameter int ADDR_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sisu_pkg::ctrl_t       ctrl_i,
  output sisu_pkg::status_t     status_o,
  input  logic [1:0]            req_type_i,
  input  logic [15:0]           address_i,
  input  logic [15:0]           word_value_i,
  input  logic [3:0]            reg_index_i,
  output logic                  done_o,
  output logic [15:0]           next_pc_o,
  output logic                  halted_o,
  output logic [2:0]            cond_code_o
);
  import sisu_pkg::*;

  logic [15:0] gpr_q [8];
  logic [15:0] pc_q;
  logic [2:0]  cc_q;
  logic [1:0]  rt_q;
  logic [15:0] addr_q, val_q, ir_q, ind_q;
  logic [3:0]  idx_q;
  logic [ADDR_BITS-1:0] clr_q;
  logic        done_q, halt_q;

  logic [15:0] rdata;
  logic [15:0] ea;
  logic [15:0] src2;
  logic [15:0] mem_addr;
  logic        mem_we;
  logic [15:0] mem_wdata;
  logic [3:0]  op;

  assign op = ir_q[15:12];
  assign src2 = ir_q[5] ? sext5(ir_q) : gpr_q[ir_q[2:0]];

  always_comb begin
    case (op)
      OP_LDR, OP_STR: ea = gpr_q[ir_q[8:6]] + sext6(ir_q);
      default:        ea = pc_q + sext9(ir_q);
    endcase
  end

  always_comb begin
    case (ctrl_i.addr_sel)
      AS_CLR:  mem_addr = 16'(clr_q);
      AS_PC:   mem_addr = pc_q;
      AS_EA:   mem_addr = ea;
      AS_IND:  mem_addr = ctrl_i.latch_ind ? rdata : ind_q;
      default: mem_addr = addr_q;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wdata = gpr_q[ir_q[11:9]];
    if (ctrl_i.clr_wr) begin
      mem_we = 1'b1;
      mem_wdata = '0;
    end else if (ctrl_i.do_req && rt_q == REQ_LOAD) begin
      mem_we = 1'b1;
      mem_wdata = val_q;
    end else if (ctrl_i.do_exec &&
                 (op == OP_ST || op == OP_STR || op == OP_STI)) begin
      mem_we = 1'b1;
    end
  end

  sisu_ram #(.WIDTH(16), .DEPTH(2 ** ADDR_BITS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (ctrl_i.mem_re),
    .addr_i (mem_addr[ADDR_BITS-1:0]),
    .wdata_i(mem_wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        gpr_q[i] <= '0;
      end
      pc_q   <= '0;
      cc_q   <= '0;
      clr_q  <= '0;
      done_q <= 1'b0;
      halt_q <= 1'b0;
      rt_q   <= REQ_LOAD;
    end else begin
      done_q <= ctrl_i.done;
      if (ctrl_i.clr_step) begin
        clr_q <= clr_q + ADDR_BITS'(1);
      end
      if (ctrl_i.latch_req) begin
        rt_q   <= req_type_i;
        halt_q <= 1'b0;
      end
      if (ctrl_i.do_req && rt_q == REQ_SET) begin
        if (idx_q < 4'd8) begin
          gpr_q[idx_q[2:0]] <= val_q;
        end else if (idx_q == IDX_PC) begin
          pc_q <= val_q;
        end else if (idx_q == IDX_CC) begin
          cc_q <= val_q[2:0];
        end
      end
      if (ctrl_i.latch_ir) begin
        pc_q   <= pc_q + 16'd1;
        halt_q <= (rdata == 16'd0);
      end
      if (ctrl_i.do_exec) begin
        case (op)
          OP_BR: begin
            if ((ir_q[11:9] & cc_q) != 3'd0) begin
              pc_q <= ea;
            end
          end
          OP_ADD: begin
            gpr_q[ir_q[11:9]] <= gpr_q[ir_q[8:6]] + src2;
            cc_q <= cc_of(gpr_q[ir_q[8:6]] + src2);
          end
          OP_AND: begin
            gpr_q[ir_q[11:9]] <= gpr_q[ir_q[8:6]] & src2;
            cc_q <= cc_of(gpr_q[ir_q[8:6]] & src2);
          end
          OP_NOT: begin
            gpr_q[ir_q[11:9]] <= ~gpr_q[ir_q[8:6]];
            cc_q <= cc_of(~gpr_q[ir_q[8:6]]);
          end
          OP_LD, OP_LDR, OP_LDI: begin
            gpr_q[ir_q[11:9]] <= rdata;
            cc_q <= cc_of(rdata);
          end
          OP_LEA: begin
            gpr_q[ir_q[11:9]] <= ea;
            cc_q <= cc_of(ea);
          end
          OP_JSR: begin
            gpr_q[7] <= pc_q;
            pc_q <= ir_q[11] ? (pc_q + sext11(ir_q)) : gpr_q[ir_q[8:6]];
          end
          OP_JMP: begin
            pc_q <= gpr_q[ir_q[8:6]];
          end
          OP_TRAP: begin
            if (ir_q[7:0] == TRAP_HALT_VEC) begin
              pc_q <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_req) begin
      addr_q <= address_i;
      val_q  <= word_value_i;
      idx_q  <= reg_index_i;
    end
    if (ctrl_i.latch_ir) begin
      ir_q <= rdata;
    end
    if (ctrl_i.latch_ind) begin
      ind_q <= rdata;
    end
  end

  assign status_o.clr_last = (clr_q == '1);
  assign status_o.req_type = rt_q;
  assign status_o.opcode   = op;

  assign done_o      = done_q;
  assign next_pc_o   = halt_q ? 16'd0 : pc_q;
  assign halted_o    = halt_q;
  assign cond_code_o = cc_q;

endmodule

/* rtl/sixteen_bit_isa_step_unit.sv */
// Top level of the 16-bit ISA step unit: one request per start, one result per request.
// Throughput: one request at a time; busy stays high until the result strobe.
// Reset: registers, PC and condition code clear at once; memory is then zeroed
// word by word with busy high. The receiver cannot stall results.
// Depends on sisu_pkg, sisu_ctrl, sisu_dp, sisu_ram.
`timescale 1ns / 1ps
module sixteen_bit_isa_step_unit #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] address_i,
  input  logic [15:0] word_value_i,
  input  logic [3:0]  reg_index_i,
  output logic        done_o,
  output logic [15:0] next_pc_o,
  output logic        halted_o,
  output logic [2:0]  cond_code_o
);
  import sisu_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  sisu_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(status),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  sisu_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .req_type_i  (req_type_i),
    .address_i   (address_i),
    .word_value_i(word_value_i),
    .reg_index_i (reg_index_i),
    .done_o      (done_o),
    .next_pc_o   (next_pc_o),
    .halted_o    (halted_o),
    .cond_code_o (cond_code_o)
  );

endmodule

/* sim/sisu_step_checker.sv */
// Checker for the 16-bit ISA step unit: watches the request and result ports,
// predicts each result from its own machine state and compares. Depends on sisu_pkg.
`timescale 1ns / 1ps
module sisu_step_checker #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] address_i,
  input  logic [15:0] word_value_i,
  input  logic [3:0]  reg_index_i,
  input  logic        done_o,
  input  logic [15:0] next_pc_o,
  input  logic        halted_o,
  input  logic [2:0]  cond_code_o,
  output int          fail_count,
  output int          pending,
  output int          step_count,
  output int          halt_count
);
  import sisu_pkg::*;

  typedef struct packed {
    logic [15:0] pc;
    logic        halt;
    logic [2:0]  cc;
  } outcome_t;

  logic [15:0] gpr [8];
  logic [15:0] pc_q;
  logic [2:0]  cc_q;
  logic [15:0] mem [1 << ADDR_BITS];
  outcome_t    outcome_q[$];

  function automatic logic [15:0] sx(input logic [15:0] w, input int bits);
    logic [15:0] m;
    m = (16'd1 << bits) - 16'd1;
    return w[bits-1] ? (w | ~m) : (w & m);
  endfunction

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v == 16'd0) return CC_Z;
    if (v[15]) return CC_N;
    return CC_P;
  endfunction

  function automatic logic [15:0] rd(input logic [15:0] a);
    return mem[a[ADDR_BITS-1:0]];
  endfunction

  task automatic wr(input logic [15:0] a, input logic [15:0] v);
    mem[a[ADDR_BITS-1:0]] = v;
  endtask

  task automatic put_reg(input logic [2:0] r, input logic [15:0] v);
    gpr[r] = v;
    cc_q = flags_of(v);
  endtask

  task automatic run_request(input logic [1:0] rq, input logic [15:0] a,
                             input logic [15:0] v, input logic [3:0] idx,
                             output outcome_t res);
    logic [15:0] w, pc, src2, tgt, off9;
    logic [2:0]  dr, sr1;
    logic        halt;
    halt = 1'b0;
    if (rq == REQ_LOAD) begin
      wr(a, v);
    end else if (rq == REQ_SET) begin
      if (idx < 4'd8) gpr[idx[2:0]] = v;
      else if (idx == IDX_PC) pc_q = v;
      else if (idx == IDX_CC) cc_q = v[2:0];
    end else if (rq == REQ_STEP) begin
      w = rd(pc_q);
      pc_q = pc_q + 16'd1;
      pc = pc_q;
      dr = w[11:9];
      sr1 = w[8:6];
      off9 = sx(w, 9);
      src2 = w[5] ? sx(w, 5) : gpr[w[2:0]];
      case (w[15:12])
        OP_BR:   if (dr & cc_q) pc_q = pc + off9;
        OP_ADD:  put_reg(dr, gpr[sr1] + src2);
        OP_LD:   put_reg(dr, rd(pc + off9));
        OP_ST:   wr(pc + off9, gpr[dr]);
        OP_JSR: begin
          tgt = w[11] ? pc + sx(w, 11) : gpr[sr1];
          gpr[7] = pc;
          pc_q = tgt;
        end
        OP_AND:  put_reg(dr, gpr[sr1] & src2);
        OP_LDR:  put_reg(dr, rd(gpr[sr1] + sx(w, 6)));
        OP_STR:  wr(gpr[sr1] + sx(w, 6), gpr[dr]);
        OP_NOT:  put_reg(dr, ~gpr[sr1]);
        OP_LDI:  put_reg(dr, rd(rd(pc + off9)));
        OP_STI:  wr(rd(pc + off9), gpr[dr]);
        OP_JMP:  pc_q = gpr[sr1];
        OP_LEA:  put_reg(dr, pc + off9);
        OP_TRAP: if (w[7:0] == TRAP_HALT_VEC) pc_q = 16'd0;
        default: ;
      endcase
      halt = (w == 16'd0);
      step_count++;
      if (halt) halt_count++;
    end
    res.pc = halt ? 16'd0 : pc_q;
    res.halt = halt;
    res.cc = cc_q;
  endtask

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    step_count = 0;
    halt_count = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t res, exp_o;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) gpr[i] = '0;
      pc_q = '0;
      cc_q = '0;
      for (int i = 0; i < (1 << ADDR_BITS); i++) mem[i] = '0;
      outcome_q.delete();
    end else begin
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          report($sformatf("result pc=%h with no request outstanding", next_pc_o));
        end else begin
          exp_o = outcome_q.pop_front();
          if (next_pc_o !== exp_o.pc)
            report($sformatf("next_pc %h, want %h", next_pc_o, exp_o.pc));
          if (halted_o !== exp_o.halt)
            report($sformatf("halted %b, want %b", halted_o, exp_o.halt));
          if (cond_code_o !== exp_o.cc)
            report($sformatf("cond_code %b, want %b", cond_code_o, exp_o.cc));
        end
      end
      if (start && !busy) begin
        run_request(req_type_i, address_i, word_value_i, reg_index_i, res);
        outcome_q.push_back(res);
      end
    end
    pending = outcome_q.size();
  end

endmodule

/* sim/tb_sixteen_bit_isa_step_unit.sv */
// Testbench top for the 16-bit ISA step unit: drives directed and random requests under
// several idle patterns and gives the verdict. Depends on sisu_pkg, sixteen_bit_isa_step_unit, sisu_step_checker.
`timescale 1ns / 1ps
module tb_sixteen_bit_isa_step_unit;
  import sisu_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [15:0] address_i = '0;
  logic [15:0] word_value_i = '0;
  logic [3:0]  reg_index_i = '0;
  logic        done_o;
  logic [15:0] next_pc_o;
  logic        halted_o;
  logic [2:0]  cond_code_o;
  int          fail_count, pending, step_count, halt_count;
  int          idle_pct = 0;
  int          request_count = 0;

  sixteen_bit_isa_step_unit dut (.*);
  sisu_step_checker chk (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending);
    $display("** sixteen_bit_isa_step_unit: FAILED **");
    $finish;
  end

  // hold the request until accepted, then maybe idle
  task automatic send(input logic [1:0] rq, input logic [15:0] a,
                      input logic [15:0] v, input logic [3:0] idx);
    start <= 1'b1;
    req_type_i <= rq;
    address_i <= a;
    word_value_i <= v;
    reg_index_i <= idx;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    request_count++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req_type_i <= 2'($urandom);
      address_i <= 16'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] rand_insn();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(19))
      0:  w = 16'd0;
      1:  w = {OP_TRAP, 4'h0, TRAP_HALT_VEC};
      2, 3: w[15:12] = OP_LDI;
      4, 5: w[15:12] = OP_STI;
      6, 7: w[15:12] = OP_BR;
      default: ;
    endcase
    return w;
  endfunction

  task automatic run_program();
    logic [15:0] base;
    int n;
    base = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63));
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) send(REQ_LOAD, base + 16'(i), rand_insn(), 4'($urandom));
    repeat ($urandom_range(0, 3)) send(REQ_SET, 16'($urandom), 16'($urandom),
                                        4'($urandom_range(0, 7)));
    send(REQ_SET, 16'($urandom), 16'($urandom), IDX_CC);
    send(REQ_SET, 16'($urandom), base, IDX_PC);
    repeat (n + 1) send(REQ_STEP, 16'($urandom), 16'($urandom), 4'($urandom));
  endtask

  task automatic noise();
    send(2'($urandom), 16'($urandom), 16'($urandom), 4'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ADD, AND, NOT, LDI, STI, JSRR, LEA, TRAP and unused opcodes, plus corner cases
    send(REQ_STEP, 16'h0000, 16'h0000, 4'd0);
    send(REQ_LOAD, 16'h0010, 16'h1A7F, 4'd0);
    send(REQ_LOAD, 16'h0011, 16'h5BE0, 4'd0);
    send(REQ_LOAD, 16'h0012, 16'h983F, 4'd0);
    send(REQ_LOAD, 16'h0013, 16'hA5FF, 4'd0);
    send(REQ_LOAD, 16'h0014, 16'hB7FE, 4'd0);
    send(REQ_LOAD, 16'h0015, 16'h41C0, 4'd0);
    send(REQ_LOAD, 16'hFFFF, 16'hE1FF, 4'd15);
    send(REQ_SET, 16'hFFFF, 16'h8000, 4'd7);
    send(REQ_SET, 16'h0000, 16'hFFFF, 4'd1);
    send(REQ_SET, 16'h0000, 16'hFFFF, IDX_CC);
    send(REQ_SET, 16'h0000, 16'h1234, 4'd12);
    send(REQ_SET, 16'h0000, 16'h0010, IDX_PC);
    repeat (6) send(REQ_STEP, 16'h0000, 16'h0000, 4'd0);
    send(REQ_SET, 16'h0000, 16'hFFFF, IDX_PC);
    send(REQ_STEP, 16'h0000, 16'h0000, 4'd0);
    send(2'd3, 16'hFFFF, 16'hFFFF, 4'd15);
    send(REQ_LOAD, 16'h0000, {OP_TRAP, 4'h0, TRAP_HALT_VEC}, 4'd0);
    send(REQ_LOAD, 16'h0001, 16'hF021, 4'd0);
    send(REQ_LOAD, 16'h0002, 16'h8000, 4'd0);
    send(REQ_LOAD, 16'h0003, 16'hD000, 4'd0);
    send(REQ_SET, 16'h0000, 16'h0001, IDX_PC);
    repeat (3) send(REQ_STEP, 16'h0000, 16'h0000, 4'd0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 81 : (ph == 2) ? 18 : 0;
      while (request_count < 25 + 375 * (ph + 1)) begin
        if ($urandom_range(9) < 8) run_program();
        else noise();
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d requests, %0d instruction steps (%0d halts) checked", request_count,
             step_count, halt_count);
    if (fail_count == 0) begin
      $display("** sixteen_bit_isa_step_unit: PASSED **");
    end else begin
      $display("** sixteen_bit_isa_step_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sisu_pkg.sv
rtl/sisu_ram.sv
rtl/sisu_ctrl.sv
rtl/sisu_dp.sv
rtl/sixteen_bit_isa_step_unit.sv
sim/sisu_step_checker.sv
sim/tb_sixteen_bit_isa_step_unit.sv
